### rtl/core/rbpt_pkg.sv
// ----------------------------------------------------------------------------
// Rolling band trader package
// Shared widths, register indexes, reset values, action codes and the
// cash saturation helper.
// ----------------------------------------------------------------------------
package rbpt_pkg;

   // Parameter defaults
   localparam int DEF_MAX_WINDOW = 256;
   localparam int DEF_PRICE_BITS = 24;

   // Fixed field widths
   localparam int WL_W       = 9;
   localparam int BAND_W     = 4;
   localparam int BM2_W      = 2 * BAND_W;
   localparam int MAXP_W     = 10;
   localparam int POS_W      = 11;
   localparam int CASH_W     = 48;
   localparam int CASH_SUM_W = CASH_W + 2;

   // Configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 11;

   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_LEN   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BAND_MULT    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_POSITION = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_POSITION = 2'd3;

   // Register reset values
   localparam logic [WL_W-1:0]          RST_WINDOW_LEN   = 9'd20;
   localparam logic [BAND_W-1:0]        RST_BAND_MULT    = 4'd2;
   localparam logic [MAXP_W-1:0]        RST_MAX_POSITION = 10'd5;
   localparam logic signed [POS_W-1:0]  RST_MIN_POSITION = -11'sd5;

   // Action codes
   typedef enum logic [1:0] {
      ACT_NONE = 2'd0,
      ACT_BUY  = 2'd1,
      ACT_SELL = 2'd2
   } action_type;

   // Clamp a widened cash sum to the signed 48-bit range
   function automatic logic signed [CASH_W-1:0] sat_cash(
      input logic signed [CASH_SUM_W-1:0] value
   );
      logic signed [CASH_SUM_W-1:0] hi_lim;
      logic signed [CASH_SUM_W-1:0] lo_lim;
      hi_lim = CASH_SUM_W'({1'b0, {(CASH_W-1){1'b1}}});
      lo_lim = -hi_lim - CASH_SUM_W'(1);
      if (value > hi_lim) begin
         sat_cash = hi_lim[CASH_W-1:0];
      end else if (value < lo_lim) begin
         sat_cash = lo_lim[CASH_W-1:0];
      end else begin
         sat_cash = value[CASH_W-1:0];
      end
   endfunction

endpackage

### rtl/core/rolling_band_position_trader.sv
// ----------------------------------------------------------------------------
// Rolling band position trader
// Band breakout trading on a rolling price window, exact integer arithmetic.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel carries one price word (price, priming flag). A word is taken
//   when req_valid is high and req_stall low; req_stall is high while a word
//   is in work and during reset. rsp_ channel returns exactly one word per
//   request: action, position, cash and settled value, held in an output
//   register until taken. csr_ port writes window_len, band_mult,
//   max_position, min_position by index; write only while the block is idle.
// Sequence:
//   a priming word goes from IDLE through SETTLE and FINISH. A trading word
//   first scans H stored prices through the single ring read port, where
//   H = min(n-1, stored prices) and n is window_len clamped to 2..MAX_WINDOW,
//   then forms d^2, S^2, n*Q and the band product on the bit-serial
//   multiplier, whose multiplier operand is W = PRICE_BITS + clog2(MAX_WINDOW+1)
//   bits wide (33 by default), then passes DECIDE, SETTLE and FINISH. One
//   word is in work at a time; req_stall falls as rsp_valid rises.
// Reset: position, cash, ring pointer and fill count clear; registers load
//   their defaults. Ring contents are not cleared, reads stop at fill count.
// Stall: a finished word waits in the output register while rsp_stall is
//   high; a new request may be accepted meanwhile and then waits at its end.
// ----------------------------------------------------------------------------
module rolling_band_position_trader
   import rbpt_pkg::*;
#(
   parameter int MAX_WINDOW = DEF_MAX_WINDOW,
   parameter int PRICE_BITS = DEF_PRICE_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [PRICE_BITS-1:0]         req_price,
   input  logic                          req_priming,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_action,
   output logic signed [POS_W-1:0]       rsp_position,
   output logic signed [CASH_W-1:0]      rsp_cash,
   output logic signed [CASH_W-1:0]      rsp_settled_value,
   input  logic                          csr_write,
   input  logic [CSR_INDEX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_data
);

   localparam int AW    = $clog2(MAX_WINDOW);
   localparam int NW    = $clog2(MAX_WINDOW + 1);
   localparam int CW    = (NW > WL_W) ? NW : WL_W;
   localparam int DW    = PRICE_BITS + NW;
   localparam int SQ_W  = 2 * PRICE_BITS + NW;
   localparam int V_W   = 2 * DW;
   localparam int PW    = V_W + BM2_W;
   localparam int PRD_W = PRICE_BITS + POS_W + 1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DIFF,
      ST_MUL_D2,
      ST_MUL_S2,
      ST_MUL_NQ,
      ST_SUBV,
      ST_MUL_RHS,
      ST_DECIDE,
      ST_SETTLE,
      ST_FINISH
   } state_type;

   // Control and configuration
   state_type                  state_ff;
   logic [WL_W-1:0]            wl_ff;
   logic [BAND_W-1:0]          bm_ff;
   logic [MAXP_W-1:0]          maxp_ff;
   logic signed [POS_W-1:0]    minp_ff;
   logic [AW-1:0]              wp_ff;
   logic [NW-1:0]              fill_ff;
   logic signed [POS_W-1:0]    pos_ff;
   logic signed [CASH_W-1:0]   cash_ff;
   logic                       rsp_valid_ff;

   // Work registers
   logic [PRICE_BITS-1:0]      price_ff;
   logic [NW-1:0]              n_ff;
   logic [DW-1:0]              np_ff;
   logic [DW-1:0]              sum_ff;
   logic [SQ_W-1:0]            sq_ff;
   logic [NW-1:0]              issue_left_ff;
   logic [AW-1:0]              rd_ptr_ff;
   logic                       rd_vld_ff;
   logic                       sq_vld_ff;
   logic [2*PRICE_BITS-1:0]    sqp_ff;
   logic [PRICE_BITS-1:0]      sqp_price_ff;
   logic                       dnonneg_ff;
   logic [DW-1:0]              dmag_ff;
   logic [V_W-1:0]             d2_ff;
   logic [V_W-1:0]             s2_ff;
   logic [V_W-1:0]             v_ff;
   logic                       band_ff;
   action_type                 action_ff;
   logic signed [PRD_W-1:0]    prod_ff;
   logic                       mul_start_ff;
   logic [V_W-1:0]             mul_a_ff;
   logic [DW-1:0]              mul_b_ff;

   // Output payload
   logic [1:0]                 rsp_action_ff;
   logic signed [POS_W-1:0]    rsp_position_ff;
   logic signed [CASH_W-1:0]   rsp_cash_ff;
   logic signed [CASH_W-1:0]   rsp_settled_ff;

   // Combinational values
   logic                       req_take;
   logic                       out_free;
   logic                       finish_go;
   logic                       mul_start_in;
   logic [CW-1:0]              wl_ext;
   logic [NW-1:0]              n_in;
   logic [NW-1:0]              n_m1;
   logic [NW-1:0]              hist_in;
   logic [AW-1:0]              wp_prev;
   logic [AW-1:0]              rd_ptr_prev;
   logic [AW-1:0]              wp_in;
   logic [NW-1:0]              fill_in;
   logic [2*PRICE_BITS-1:0]    price_sq_in;
   logic [DW-1:0]              np_in;
   logic                       rd_en;
   logic [PRICE_BITS-1:0]      rd_data;
   logic [2*PRICE_BITS-1:0]    rd_sq_in;
   logic [V_W-1:0]             v_in;
   logic                       mul_done;
   logic [PW-1:0]              mul_product;
   logic                       band_in;
   logic signed [POS_W:0]      pos_x;
   logic signed [POS_W:0]      maxp_x;
   logic signed [POS_W:0]      minp_x;
   logic signed [CASH_SUM_W-1:0] price_x;
   logic signed [CASH_SUM_W-1:0] cash_x;
   logic signed [CASH_W-1:0]   cash_buy_in;
   logic signed [CASH_W-1:0]   cash_sell_in;
   logic signed [PRD_W-1:0]    prod_in;
   logic signed [CASH_SUM_W-1:0] settle_sum_in;
   logic signed [CASH_W-1:0]   settled_in;

   // Handshake
   assign req_stall = reset || (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign finish_go = (state_ff == ST_FINISH) && out_free;

   // Launch the next product as each stage finishes
   assign mul_start_in = (state_ff == ST_DIFF) || (state_ff == ST_SUBV) ||
                         (((state_ff == ST_MUL_D2) || (state_ff == ST_MUL_S2)) && mul_done);

   // Clamp window length and limit history to stored prices
   always_comb begin
      wl_ext = CW'(wl_ff);
      if (wl_ext < CW'(2)) begin
         n_in = NW'(2);
      end else if (wl_ext > CW'(MAX_WINDOW)) begin
         n_in = NW'(MAX_WINDOW);
      end else begin
         n_in = NW'(wl_ext);
      end
      n_m1    = n_in - 1'b1;
      hist_in = (n_m1 > fill_ff) ? fill_ff : n_m1;
   end

   // Ring pointer steps with wrap at the depth
   assign wp_prev     = (wp_ff == '0) ? AW'(MAX_WINDOW - 1) : wp_ff - 1'b1;
   assign rd_ptr_prev = (rd_ptr_ff == '0) ? AW'(MAX_WINDOW - 1) : rd_ptr_ff - 1'b1;
   assign wp_in       = (wp_ff == AW'(MAX_WINDOW - 1)) ? '0 : wp_ff + 1'b1;
   assign fill_in     = (fill_ff < NW'(MAX_WINDOW)) ? fill_ff + 1'b1 : fill_ff;

   // Seed the window with the incoming price
   assign price_sq_in = req_price * req_price;
   assign np_in       = n_in * req_price;

   // Scan reads and squares
   assign rd_en    = (state_ff == ST_SCAN) && (issue_left_ff != '0);
   assign rd_sq_in = rd_data * rd_data;

   // Variance numerator, floored at zero
   assign v_in    = (v_ff >= s2_ff) ? v_ff - s2_ff : '0;
   assign band_in = (PW'(d2_ff) >= mul_product);

   // Position limits and cash moves
   assign pos_x        = {pos_ff[POS_W-1], pos_ff};
   assign maxp_x       = $signed({2'b00, maxp_ff});
   assign minp_x       = {minp_ff[POS_W-1], minp_ff};
   assign price_x      = $signed(CASH_SUM_W'(price_ff));
   assign cash_x       = CASH_SUM_W'(cash_ff);
   assign cash_buy_in  = sat_cash(cash_x - price_x);
   assign cash_sell_in = sat_cash(cash_x + price_x);

   // Mark to market
   assign prod_in       = pos_ff * $signed({1'b0, price_ff});
   assign settle_sum_in = cash_x + CASH_SUM_W'(prod_ff);
   assign settled_in    = sat_cash(settle_sum_in);

   // Price ring
   rbpt_ring #(
      .DEPTH  (MAX_WINDOW),
      .DATA_W (PRICE_BITS)
   ) u_ring (
      .clock   (clock),
      .wr_en   (finish_go),
      .wr_addr (wp_ff),
      .wr_data (price_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_ptr_ff),
      .rd_data (rd_data)
   );

   // Shared multiplier
   rbpt_mul #(
      .A_W (V_W),
      .B_W (DW),
      .P_W (PW)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start_ff),
      .a       (mul_a_ff),
      .b       (mul_b_ff),
      .done    (mul_done),
      .product (mul_product)
   );

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wl_ff   <= RST_WINDOW_LEN;
         bm_ff   <= RST_BAND_MULT;
         maxp_ff <= RST_MAX_POSITION;
         minp_ff <= RST_MIN_POSITION;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_WINDOW_LEN:   wl_ff   <= csr_data[WL_W-1:0];
            CSR_BAND_MULT:    bm_ff   <= csr_data[BAND_W-1:0];
            CSR_MAX_POSITION: maxp_ff <= csr_data[MAXP_W-1:0];
            CSR_MIN_POSITION: minp_ff <= $signed(csr_data[POS_W-1:0]);
         endcase
      end
   end

   // Sequencer: state, trading state and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= '0;
         fill_ff      <= '0;
         pos_ff       <= '0;
         cash_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         rd_vld_ff    <= 1'b0;
         sq_vld_ff    <= 1'b0;
         mul_start_ff <= 1'b0;
      end else begin
         mul_start_ff <= mul_start_in;
         rd_vld_ff    <= rd_en;
         sq_vld_ff    <= rd_vld_ff;

         // Load the output word on finish, drop it once taken
         if (finish_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_take) begin
                  price_ff      <= req_price;
                  action_ff     <= ACT_NONE;
                  sum_ff        <= DW'(req_price);
                  sq_ff         <= SQ_W'(price_sq_in);
                  np_ff         <= np_in;
                  n_ff          <= n_in;
                  issue_left_ff <= hist_in;
                  rd_ptr_ff     <= wp_prev;
                  state_ff      <= req_priming ? ST_SETTLE : ST_SCAN;
               end
            end

            ST_SCAN: begin
               // Issue reads, square returning words, accumulate
               if (rd_en) begin
                  rd_ptr_ff     <= rd_ptr_prev;
                  issue_left_ff <= issue_left_ff - 1'b1;
               end
               if (rd_vld_ff) begin
                  sqp_ff       <= rd_sq_in;
                  sqp_price_ff <= rd_data;
               end
               if (sq_vld_ff) begin
                  sum_ff <= sum_ff + DW'(sqp_price_ff);
                  sq_ff  <= sq_ff + SQ_W'(sqp_ff);
               end
               if ((issue_left_ff == '0) && !rd_vld_ff && !sq_vld_ff) begin
                  state_ff <= ST_DIFF;
               end
            end

            ST_DIFF: begin
               dnonneg_ff   <= (np_ff >= sum_ff);
               dmag_ff      <= (np_ff >= sum_ff) ? np_ff - sum_ff : sum_ff - np_ff;
               mul_a_ff     <= V_W'((np_ff >= sum_ff) ? np_ff - sum_ff : sum_ff - np_ff);
               mul_b_ff     <= (np_ff >= sum_ff) ? np_ff - sum_ff : sum_ff - np_ff;
               state_ff     <= ST_MUL_D2;
            end

            ST_MUL_D2: begin
               if (mul_done) begin
                  d2_ff        <= mul_product[V_W-1:0];
                  mul_a_ff     <= V_W'(sum_ff);
                  mul_b_ff     <= sum_ff;
                  state_ff     <= ST_MUL_S2;
               end
            end

            ST_MUL_S2: begin
               if (mul_done) begin
                  s2_ff        <= mul_product[V_W-1:0];
                  mul_a_ff     <= V_W'(sq_ff);
                  mul_b_ff     <= DW'(n_ff);
                  state_ff     <= ST_MUL_NQ;
               end
            end

            ST_MUL_NQ: begin
               if (mul_done) begin
                  v_ff     <= mul_product[V_W-1:0];
                  state_ff <= ST_SUBV;
               end
            end

            ST_SUBV: begin
               mul_a_ff     <= v_in;
               mul_b_ff     <= DW'(BM2_W'(bm_ff) * BM2_W'(bm_ff));
               state_ff     <= ST_MUL_RHS;
            end

            ST_MUL_RHS: begin
               if (mul_done) begin
                  band_ff  <= band_in;
                  state_ff <= ST_DECIDE;
               end
            end

            ST_DECIDE: begin
               // Buy above the band, sell below it, within the limits
               priority if (dnonneg_ff && band_ff) begin
                  if (pos_x < maxp_x) begin
                     pos_ff    <= pos_ff + 1'b1;
                     cash_ff   <= cash_buy_in;
                     action_ff <= ACT_BUY;
                  end
               end else if ((dmag_ff == '0) || !dnonneg_ff) begin
                  if (band_ff && (pos_x > minp_x)) begin
                     pos_ff    <= pos_ff - 1'b1;
                     cash_ff   <= cash_sell_in;
                     action_ff <= ACT_SELL;
                  end
               end else begin
                  action_ff <= ACT_NONE;
               end
               state_ff <= ST_SETTLE;
            end

            ST_SETTLE: begin
               prod_ff  <= prod_in;
               state_ff <= ST_FINISH;
            end

            ST_FINISH: begin
               // Hold until the output register frees, then store the price
               if (out_free) begin
                  rsp_action_ff   <= action_ff;
                  rsp_position_ff <= pos_ff;
                  rsp_cash_ff     <= cash_ff;
                  rsp_settled_ff  <= settled_in;
                  wp_ff           <= wp_in;
                  fill_ff         <= fill_in;
                  state_ff        <= ST_IDLE;
               end
            end

            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_action        = rsp_action_ff;
   assign rsp_position      = rsp_position_ff;
   assign rsp_cash          = rsp_cash_ff;
   assign rsp_settled_value = rsp_settled_ff;

endmodule

### rtl/core/rbpt_ring.sv
// ----------------------------------------------------------------------------
// Price ring memory
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module rbpt_ring #(
   parameter int DEPTH  = 256,
   parameter int DATA_W = 24
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // Write one price
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Register the read word
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/rbpt_mul.sv
// ----------------------------------------------------------------------------
// Shift-add multiplier
// Unsigned product, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module rbpt_mul #(
   parameter int A_W = 82,
   parameter int B_W = 33,
   parameter int P_W = 90
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [A_W-1:0] a,
   input  logic [B_W-1:0] b,
   output logic           done,
   output logic [P_W-1:0] product
);

   localparam int CNT_W = $clog2(B_W + 1);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [P_W-1:0]   acc_ff;
   logic [P_W-1:0]   a_sh_ff;
   logic [B_W-1:0]   b_sh_ff;

   // Sequence control: count bits, pulse done after the last one
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && !start && (cnt_ff == CNT_W'(1));
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(B_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   // Datapath: add the shifted multiplicand where the low bit is set
   always_ff @(posedge clock) begin
      if (start) begin
         acc_ff  <= '0;
         a_sh_ff <= P_W'(a);
         b_sh_ff <= b;
      end else if (busy_ff) begin
         if (b_sh_ff[0]) begin
            acc_ff <= acc_ff + a_sh_ff;
         end
         a_sh_ff <= a_sh_ff << 1;
         b_sh_ff <= b_sh_ff >> 1;
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

### sim/rolling_band_position_trader_test.sv
// ----------------------------------------------------------------------------
// Rolling band position trader testbench
// Feeds price words (priming and trading) through the request channel under
// several register settings and idle patterns. A local band-trading model
// predicts action, position, cash and settled value for every accepted word,
// and each returned word is checked field by field against it.
// ----------------------------------------------------------------------------
module rolling_band_position_trader_test;
   import rbpt_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int     PB          = DEF_PRICE_BITS;
   localparam int     MAX_WIN     = DEF_MAX_WINDOW;
   localparam int     PRICE_TOP   = (1 << PB) - 1;
   localparam longint CASH_TOP    = 64'sh0000_7FFF_FFFF_FFFF;
   localparam int     LONG_HOLD   = 1500;
   localparam int     TAIL_CYCLES = 500;
   localparam int     CYCLE_LIMIT = 3000000;

   typedef struct {
      logic [PB-1:0] price;
      logic          priming;
   } tick_type;

   typedef struct {
      action_type                action;
      logic signed [POS_W-1:0]   position;
      logic signed [CASH_W-1:0]  cash;
      logic signed [CASH_W-1:0]  settled;
   } report_type;

   // DUT ports
   logic                     clock       = 1'b0;
   logic                     reset       = 1'b1;
   logic                     req_valid   = 1'b0;
   logic                     req_stall;
   logic [PB-1:0]            req_price   = '0;
   logic                     req_priming = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_stall   = 1'b0;
   logic [1:0]               rsp_action;
   logic signed [POS_W-1:0]  rsp_position;
   logic signed [CASH_W-1:0] rsp_cash;
   logic signed [CASH_W-1:0] rsp_settled_value;
   logic                     csr_write   = 1'b0;
   logic [CSR_INDEX_W-1:0]   csr_index   = '0;
   logic [CSR_DATA_W-1:0]    csr_data    = '0;

   // Stimulus and expected result stores
   tick_type   tick_queue[$];
   report_type due_reports[$];

   // Trader model state and its copy of the registers
   logic [PB-1:0] seen_prices [MAX_WIN];
   logic [7:0]    seen_wp    = '0;
   int            seen_count = 0;
   int            held_units = 0;
   longint        cash_now   = 0;
   int            cfg_window = int'(RST_WINDOW_LEN);
   int            cfg_band   = int'(RST_BAND_MULT);
   int            cfg_max    = int'(RST_MAX_POSITION);
   int            cfg_min    = int'(RST_MIN_POSITION);

   // Idle control and bookkeeping
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int holds_asked    = 0;
   int holds_done     = 0;
   int hold_left      = 0;
   int cycle_count    = 0;
   int error_count    = 0;
   int words_sent     = 0;
   int primes_sent    = 0;
   int words_checked  = 0;
   int buys_seen      = 0;
   int sells_seen     = 0;
   int phases_run     = 0;

   rolling_band_position_trader i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_price         (req_price),
      .req_priming       (req_priming),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_action        (rsp_action),
      .rsp_position      (rsp_position),
      .rsp_cash          (rsp_cash),
      .rsp_settled_value (rsp_settled_value),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   // Clock: 12 ns period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Clamp to the signed 48-bit cash range
   function automatic longint clamp_cash(input longint value);
      if (value > CASH_TOP) begin
         return CASH_TOP;
      end
      if (value < -CASH_TOP - 1) begin
         return -CASH_TOP - 1;
      end
      return value;
   endfunction

   // Predict the report for one price word and advance the trader state
   function automatic report_type settle_tick(input logic [PB-1:0] price, input logic priming);
      report_type   rep;
      int           n;
      int           hist;
      int           k;
      logic [7:0]   idx;
      logic [127:0] pr;
      logic [127:0] p;
      logic [127:0] tot;
      logic [127:0] tot_sq;
      logic [127:0] np;
      logic [127:0] dmag;
      logic [127:0] d2;
      logic [127:0] nq;
      logic [127:0] s2;
      logic [127:0] spread;
      logic [127:0] limit;
      logic         dnonneg;
      logic         band;
      rep.action = ACT_NONE;
      if (!priming) begin
         n = cfg_window;
         if (n < 2) begin
            n = 2;
         end
         if (n > MAX_WIN) begin
            n = MAX_WIN;
         end
         // Missing history counts as zero; the divisor stays n
         hist = n - 1;
         if (hist > seen_count) begin
            hist = seen_count;
         end
         pr = 128'(price);
         tot = pr;
         tot_sq = pr * pr;
         for (k = 1; k <= hist; k++) begin
            idx = seen_wp - 8'(k);
            p = 128'(seen_prices[idx]);
            tot = tot + p;
            tot_sq = tot_sq + p * p;
         end
         np = 128'(n) * pr;
         dnonneg = (np >= tot);
         dmag = dnonneg ? np - tot : tot - np;
         d2 = dmag * dmag;
         nq = tot_sq * 128'(n);
         s2 = tot * tot;
         spread = (nq >= s2) ? nq - s2 : '0;
         limit = spread * 128'(cfg_band * cfg_band);
         band = (d2 >= limit);
         // Buy takes priority; sell only when the buy test fails
         if (dnonneg && band) begin
            if (held_units < cfg_max) begin
               held_units++;
               cash_now = clamp_cash(cash_now - longint'(price));
               rep.action = ACT_BUY;
            end
         end else if (dmag == 0 || !dnonneg) begin
            if (band && held_units > cfg_min) begin
               held_units--;
               cash_now = clamp_cash(cash_now + longint'(price));
               rep.action = ACT_SELL;
            end
         end
      end
      seen_prices[seen_wp] = price;
      seen_wp++;
      if (seen_count < MAX_WIN) begin
         seen_count++;
      end
      rep.position = POS_W'(held_units);
      rep.cash     = CASH_W'(cash_now);
      rep.settled  = CASH_W'(clamp_cash(cash_now + longint'(held_units) * longint'(price)));
      return rep;
   endfunction

   // Random walk of the market level, with spikes, flat spots and extremes
   function automatic int drift(input int level);
      int r;
      r = $urandom_range(99);
      if (r < 5) begin
         return (r < 2) ? 0 : PRICE_TOP;
      end
      if (r < 15) begin
         level = level + int'($urandom_range(0, 1 << 22)) - (1 << 21);
      end else if (r >= 25) begin
         level = level + int'($urandom_range(0, 512)) - 256;
      end
      if (level < 0) begin
         level = 0;
      end
      if (level > PRICE_TOP) begin
         level = PRICE_TOP;
      end
      return level;
   endfunction

   task automatic push_tick(input logic [PB-1:0] price, input logic priming);
      tick_type t;
      t.price = price;
      t.priming = priming;
      tick_queue.insert(tick_queue.size(), t);
   endtask

   // Write one register and mirror it in the model
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index, input int value);
      logic [CSR_DATA_W-1:0] data;
      data = CSR_DATA_W'(value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      csr_write <= 1'b0;
      case (index)
         CSR_WINDOW_LEN:   cfg_window = int'(data[WL_W-1:0]);
         CSR_BAND_MULT:    cfg_band   = int'(data[BAND_W-1:0]);
         CSR_MAX_POSITION: cfg_max    = int'(data[MAXP_W-1:0]);
         CSR_MIN_POSITION: cfg_min    = int'($signed(data[POS_W-1:0]));
         default: ;
      endcase
   endtask

   task automatic set_config(input int wl, input int bm, input int maxp, input int minp);
      write_csr(CSR_WINDOW_LEN, wl);
      write_csr(CSR_BAND_MULT, bm);
      write_csr(CSR_MAX_POSITION, maxp);
      write_csr(CSR_MIN_POSITION, minp);
      phases_run++;
   endtask

   // Wait until every queued word is taken and answered
   task automatic await_drain;
      do begin
         @(negedge clock);
      end while (tick_queue.size() != 0 || req_valid || due_reports.size() != 0);
   endtask

   // One setting: prime part of the window, then trade a random market with some noise
   task automatic run_phase(input int wl, input int bm, input int maxp, input int minp,
                            input int send_pct, input int recv_pct, input int count,
                            input bit long_hold);
      int level;
      int primes;
      int r;
      set_config(wl, bm, maxp, minp);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      level  = $urandom_range(0, PRICE_TOP);
      primes = $urandom_range(0, (wl > MAX_WIN) ? MAX_WIN : wl);
      repeat (primes) begin
         push_tick(PB'(level), 1'b1);
         level = drift(level);
      end
      repeat (count) begin
         r = $urandom_range(99);
         if (r < 8) begin
            push_tick(PB'($urandom), 1'($urandom_range(0, 1)));
         end else begin
            push_tick(PB'(level), (r < 16));
            level = drift(level);
         end
      end
      if (long_hold) begin
         holds_asked++;
      end
      await_drain;
   endtask

   // Sender: offer queued words, hold the payload while stalled
   always @(posedge clock) begin : drive_ticks
      tick_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            due_reports.insert(due_reports.size(), settle_tick(req_price, req_priming));
            words_sent++;
            if (req_priming) begin
               primes_sent++;
            end
         end
         if (!req_valid || !req_stall) begin
            if (tick_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = tick_queue.pop_front();
               req_valid   <= 1'b1;
               req_price   <= nxt.price;
               req_priming <= nxt.priming;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver stall: long hold-off on request, random stalls otherwise
   always @(posedge clock) begin : drive_stall
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (holds_done != holds_asked) begin
         holds_done = holds_asked;
         hold_left  = LONG_HOLD;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // Monitor: compare each taken word with the oldest prediction
   always @(posedge clock) begin : check_reports
      report_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rsp_action == ACT_BUY) begin
            buys_seen++;
         end
         if (rsp_action == ACT_SELL) begin
            sells_seen++;
         end
         if (due_reports.size() == 0) begin
            $display("%0t: unexpected result word, action %0d position %0d", $time,
                     rsp_action, rsp_position);
            error_count++;
         end else begin
            want = due_reports.pop_front();
            words_checked++;
            if (rsp_action !== want.action) begin
               $display("%0t: action mismatch, expected %0d, actual %0d", $time,
                        want.action, rsp_action);
               error_count++;
            end
            if (rsp_position !== want.position) begin
               $display("%0t: position mismatch, expected %0d, actual %0d", $time,
                        want.position, rsp_position);
               error_count++;
            end
            if (rsp_cash !== want.cash) begin
               $display("%0t: cash mismatch, expected %0d, actual %0d", $time,
                        want.cash, rsp_cash);
               error_count++;
            end
            if (rsp_settled_value !== want.settled) begin
               $display("%0t: settled value mismatch, expected %0d, actual %0d", $time,
                        want.settled, rsp_settled_value);
               error_count++;
            end
         end
      end
   end

   // Watchdog
   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("FAILURE");
      $finish;
   end

   initial begin : run_test
      int k;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset settings: trade on empty history, extremes of price and priming
      push_tick(PB'(PRICE_TOP), 1'b0);
      push_tick('0, 1'b0);
      push_tick('0, 1'b1);
      push_tick(PB'(PRICE_TOP), 1'b1);
      push_tick(24'h800000, 1'b0);
      push_tick(24'h000001, 1'b0);
      push_tick(24'h7FFFFF, 1'b0);
      push_tick(PB'(PRICE_TOP), 1'b0);
      await_drain;

      // Zero band: every word passes the band test. Flat prices buy, up to the top
      // limit, once the window holds only them; falling prices sell, down to the bottom limit.
      set_config(3, 0, 2, -2);
      repeat (6) push_tick(24'd5000, 1'b0);
      for (k = 4; k >= 0; k--) begin
         push_tick(PB'(k * 1000 + 500), 1'b0);
      end
      await_drain;

      // Window below range and a bottom limit above zero
      set_config(0, 15, 1023, 1);
      push_tick(24'd100, 1'b1);
      push_tick(24'd50, 1'b0);
      push_tick(24'd200, 1'b0);
      await_drain;

      // Random markets across settings and idle patterns
      run_phase(20, 2, 5, -5, 0, 0, 100, 1'b0);
      run_phase(2, 15, 1023, -1024, 49, 0, 220, 1'b0);
      run_phase(8, 1, 3, -3, 0, 49, 220, 1'b0);
      run_phase(256, 3, 10, -10, 19, 19, 50, 1'b0);
      run_phase(0, 0, 0, 0, 49, 0, 200, 1'b0);
      run_phase(511, 2, 2, -2, 0, 49, 40, 1'b0);
      run_phase(5, 2, 0, 3, 19, 19, 180, 1'b0);
      run_phase(1, 1, 7, -1, 0, 0, 200, 1'b1);
      run_phase(12, 2, 20, -20, 19, 19, 220, 1'b0);
      repeat (2) begin
         run_phase($urandom_range(2, 40), $urandom_range(0, 15), $urandom_range(0, 30),
                   -int'($urandom_range(0, 30)), 19, 19, 40, 1'b0);
      end

      // Let any stray word show up
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("Covered %0d price words (%0d priming) over %0d register settings.",
               words_sent, primes_sent, phases_run);
      $display("Checked %0d result words: %0d buys, %0d sells, %0d errors.",
               words_checked, buys_seen, sells_seen, error_count);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

### rolling_band_position_trader.f
rtl/core/rbpt_pkg.sv
rtl/core/rbpt_ring.sv
rtl/core/rbpt_mul.sv
rtl/core/rolling_band_position_trader.sv
sim/rolling_band_position_trader_test.sv
